// ===== rtl/core/wtlf_pkg.sv =====
// ----------------------------------------------------------------------------
// wtlf_pkg
// Shared types, register codes and helpers for the word template letter
// filter.
// ----------------------------------------------------------------------------
package wtlf_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgMinLength    = 3'd0,
    CfgMaxLength    = 3'd1,
    CfgOptions      = 3'd2,
    CfgTemplateLow  = 3'd3,
    CfgTemplateHigh = 3'd4,
    CfgBagLow       = 3'd5,
    CfgBagHigh      = 3'd6,
    CfgUnused       = 3'd7
  } cfg_idx_e;

  // Bag test modes, options bits 3:2
  typedef enum logic [1:0] {
    BagExact   = 2'd0,
    BagSubset  = 2'd1,
    BagExclude = 2'd2,
    BagOff     = 2'd3
  } bag_mode_e;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned SlotCount = 16;
  localparam int unsigned LenW      = 7;

  localparam logic [7:0] HyphenChar = 8'h2D;
  localparam logic [7:0] StarChar   = 8'h2A;

  localparam logic [LenW-1:0] MinLengthReset = 7'd0;
  localparam logic [LenW-1:0] MaxLengthReset = 7'd127;
  localparam logic [3:0]      OptionsReset   = 4'd12;

  // Input beat
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       no_char;
  } in_t;

  // Result beat
  typedef struct packed {
    logic            accept;
    logic [LenW-1:0] word_length;
  } out_t;

  // Control shared by every bag cell
  typedef struct packed {
    logic [7:0] ch;
    logic       step;
    logic       reuse;
    logic       clear;
  } bag_ctrl_t;

  // Uppercase one ASCII byte
  function automatic logic [7:0] upcase(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/wtlf_bag_cell.sv =====
// ----------------------------------------------------------------------------
// wtlf_bag_cell
// One letter bag slot: compares the character, keeps its used flag and
// hands the found token on to the next slot.
// ----------------------------------------------------------------------------
module wtlf_bag_cell import wtlf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bag_ctrl_t  ctrl_i,
  input  logic [7:0] slot_i,
  input  logic       found_i,
  output logic       found_o,
  output logic       match_o,
  output logic       used_o
);

  logic used_q, used_d;
  logic hit;

  // Claim this slot when no earlier slot took the character
  always_comb begin
    match_o = (slot_i != 8'h00) && (slot_i == ctrl_i.ch);
    hit     = ctrl_i.step && match_o && !found_i && (ctrl_i.reuse || !used_q);
    found_o = found_i | hit;
    used_o  = used_q | (hit & ~ctrl_i.reuse);
    used_d  = ctrl_i.clear ? 1'b0 : used_o;
  end

  // Hold the used flag until the word ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

endmodule

// ===== rtl/core/wtlf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// wtlf_out_fifo
// Two-entry result buffer that parts the input side from the output stall.
// ----------------------------------------------------------------------------
module wtlf_out_fifo import wtlf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  out_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  // Store a result beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/word_template_letter_filter_core.sv =====
// ----------------------------------------------------------------------------
// word_template_letter_filter_core
// Streams the characters of a word and gives an accept verdict at its end.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//   out     | output    | out_valid_o/ out_stall_i| out_data_o (out_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One character beat per cycle unless stalled; the whole check of a
// character, including the claim search along the row of bag cells,
// completes in that cycle. The last beat writes the verdict into the
// result buffer. Reset clears the word state and that buffer and loads
// the register defaults. The input stalls only while both entries wait.
// ----------------------------------------------------------------------------
module word_template_letter_filter_core import wtlf_pkg::*; #(
  parameter int unsigned TEMPLATE_CHARS  = 16,
  parameter int unsigned BAG_LETTERS     = 16,
  parameter int unsigned MAX_WORD_LENGTH = 127
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [LenW-1:0] MaxLen   = LenW'(MAX_WORD_LENGTH);
  localparam logic [LenW-1:0] TmplLen  = LenW'(TEMPLATE_CHARS);

  // Configuration registers
  logic [LenW-1:0]     min_len_q, max_len_q;
  logic [3:0]          opt_q;
  logic [CfgDataW-1:0] tmpl_lo_q, tmpl_hi_q, bag_lo_q, bag_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLengthReset;
      max_len_q <= MaxLengthReset;
      opt_q     <= OptionsReset;
      tmpl_lo_q <= '0;
      tmpl_hi_q <= '0;
      bag_lo_q  <= '0;
      bag_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMinLength:    min_len_q <= cfg_wdata_i[LenW-1:0];
        CfgMaxLength:    max_len_q <= cfg_wdata_i[LenW-1:0];
        CfgOptions:      opt_q     <= cfg_wdata_i[3:0];
        CfgTemplateLow:  tmpl_lo_q <= cfg_wdata_i;
        CfgTemplateHigh: tmpl_hi_q <= cfg_wdata_i;
        CfgBagLow:       bag_lo_q  <= cfg_wdata_i;
        CfgBagHigh:      bag_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic      allow_hyphen, reuse;
  bag_mode_e mode;
  assign allow_hyphen = opt_q[0];
  assign reuse        = opt_q[1];
  assign mode         = bag_mode_e'(opt_q[3:2]);

  // Unpack and uppercase template and bag bytes
  logic [7:0]           tmpl [SlotCount];
  logic [7:0]           slot [SlotCount];
  logic [SlotCount-1:0] tmpl_live;
  logic                 bag_active;

  always_comb begin
    logic run;
    run        = 1'b1;
    bag_active = 1'b0;
    for (int k = 0; k < SlotCount; k++) begin
      if (k < 8) begin
        tmpl[k] = upcase(tmpl_lo_q[8*k +: 8]);
        slot[k] = upcase(bag_lo_q[8*k +: 8]);
      end else begin
        tmpl[k] = upcase(tmpl_hi_q[8*(k-8) +: 8]);
        slot[k] = upcase(bag_hi_q[8*(k-8) +: 8]);
      end
      run          = run && (tmpl[k] != 8'h00) && (k < TEMPLATE_CHARS);
      tmpl_live[k] = run;
      if (k < BAG_LETTERS && slot[k] != 8'h00 && slot[k] != StarChar) begin
        bag_active = 1'b1;
      end
    end
  end

  // Word state
  logic [LenW-1:0] cnt_q, cnt_d, cnt_next;
  logic            rejected_q, rejected_d, rej_next;

  logic in_fire, take_char, word_end;
  logic push, fifo_full;
  assign in_stall_o = fifo_full;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign take_char  = in_fire && !in_data_i.no_char;
  assign word_end   = in_fire && in_data_i.last;
  assign push       = word_end;

  // Row of bag cells; the found token runs from slot 0 upwards
  bag_ctrl_t              ctrl;
  logic [BAG_LETTERS:0]   found;
  logic [BAG_LETTERS-1:0] match, used;

  assign ctrl.ch    = in_data_i.ch;
  assign ctrl.step  = take_char && bag_active && (mode == BagExact || mode == BagSubset);
  assign ctrl.reuse = reuse;
  assign ctrl.clear = word_end;
  assign found[0]   = 1'b0;

  for (genvar g = 0; g < BAG_LETTERS; g++) begin : g_cell
    wtlf_bag_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .slot_i  (slot[g]),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .match_o (match[g]),
      .used_o  (used[g])
    );
  end

  // Judge the character and the word
  logic tmpl_fail, hyph_fail, bag_fail, exact_fail, len_ok;
  logic [7:0] tch;
  out_t res;

  always_comb begin
    tch       = tmpl[cnt_q[3:0]];
    hyph_fail = !allow_hyphen && (in_data_i.ch == HyphenChar);
    tmpl_fail = (cnt_q < TmplLen) && tmpl_live[cnt_q[3:0]]
                && (tch != in_data_i.ch) && (tch != StarChar);
    bag_fail  = 1'b0;
    if (bag_active) begin
      if (mode == BagExact || mode == BagSubset) begin
        bag_fail = !found[BAG_LETTERS];
      end else if (mode == BagExclude) begin
        bag_fail = |match;
      end
    end
    rej_next = rejected_q | (take_char & (hyph_fail | tmpl_fail | bag_fail));

    cnt_next = cnt_q;
    if (take_char && cnt_q < MaxLen) begin
      cnt_next = cnt_q + 1'b1;
    end

    exact_fail = 1'b0;
    if (bag_active && mode == BagExact && !reuse) begin
      for (int k = 0; k < BAG_LETTERS; k++) begin
        if (slot[k] != 8'h00 && !used[k]) begin
          exact_fail = 1'b1;
        end
      end
    end
    len_ok = (cnt_next >= min_len_q) && (cnt_next <= max_len_q);

    res.accept      = !rej_next && len_ok && !exact_fail;
    res.word_length = cnt_next;

    cnt_d      = word_end ? '0 : cnt_next;
    rejected_d = word_end ? 1'b0 : rej_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rejected_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      rejected_q <= rejected_d;
    end
  end

  // Buffer verdicts
  wtlf_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // Checks
  a_stall_has_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxLen)
    else $error("character count beyond saturation");

  a_word_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_end |=> (cnt_q == '0 && !rejected_q))
    else $error("word state not cleared after last beat");

  a_verdict_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_end && !out_valid_o) |=> out_valid_o)
    else $error("verdict not presented after last beat");

endmodule

// ===== verif/word_template_letter_filter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word_template_letter_filter_core_tb
// Self-checking bench for the word filter. Words are streamed one character
// beat at a time under several register settings, and every verdict is
// compared with a cycle-free prediction of the filter kept in a scoreboard.
// ----------------------------------------------------------------------------
module word_template_letter_filter_core_tb;
  import wtlf_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseBeats  = 155;
  localparam int unsigned ReportLimit = 10;

  // Prediction of the filter: register copies, word state, pending verdicts
  class verdict_board;
    logic [6:0]   min_len;
    logic [6:0]   max_len;
    logic [3:0]   opts;
    logic [127:0] tmpl;
    logic [127:0] bag;
    logic [6:0]   count;
    bit           rejected;
    logic [15:0]  used;
    out_t         pending[$];
    int           errors;
    int           verdicts;

    function new();
      min_len  = MinLengthReset;
      max_len  = MaxLengthReset;
      opts     = OptionsReset;
      tmpl     = '0;
      bag      = '0;
      errors   = 0;
      verdicts = 0;
      clear_word();
    endfunction

    function void clear_word();
      count    = '0;
      rejected = 1'b0;
      used     = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] val);
      case (idx)
        CfgMinLength:    min_len = val[6:0];
        CfgMaxLength:    max_len = val[6:0];
        CfgOptions:      opts = val[3:0];
        CfgTemplateLow:  tmpl[63:0] = val;
        CfgTemplateHigh: tmpl[127:64] = val;
        CfgBagLow:       bag[63:0] = val;
        CfgBagHigh:      bag[127:64] = val;
        default: ;
      endcase
    endfunction

    // Lower-case ASCII letters fold onto upper case
    function logic [7:0] fold_case(logic [7:0] b);
      if (b >= 8'h61 && b <= 8'h7A) return b ^ 8'h20;
      return b;
    endfunction

    function logic [7:0] tmpl_at(int k);
      return fold_case(tmpl[8*k +: 8]);
    endfunction

    function logic [7:0] bag_at(int k);
      return fold_case(bag[8*k +: 8]);
    endfunction

    // The bag only counts once it holds something other than stars
    function bit bag_live();
      for (int k = 0; k < SlotCount; k++) begin
        if (bag_at(k) != 8'h00 && bag_at(k) != StarChar) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_char(logic [7:0] ch);
      bit found;
      logic [7:0] t;
      logic [7:0] b;

      if (!opts[0] && ch == HyphenChar) rejected = 1'b1;

      // template: stop at the terminator or at this position
      for (int k = 0; k < SlotCount; k++) begin
        t = tmpl_at(k);
        if (t == 8'h00) break;
        if (k == count) begin
          if (t != ch && t != StarChar) rejected = 1'b1;
          break;
        end
      end

      if (bag_live()) begin
        case (bag_mode_e'(opts[3:2]))
          BagExact, BagSubset: begin
            found = 1'b0;
            for (int k = 0; k < SlotCount; k++) begin
              b = bag_at(k);
              if (b == 8'h00 || b != ch) continue;
              if (opts[1]) begin
                found = 1'b1;
                break;
              end
              if (!used[k]) begin
                used[k] = 1'b1;
                found = 1'b1;
                break;
              end
            end
            if (!found) rejected = 1'b1;
          end
          BagExclude: begin
            for (int k = 0; k < SlotCount; k++) begin
              b = bag_at(k);
              if (b != 8'h00 && b == ch) rejected = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (count < 7'd127) count++;
    endfunction

    // Note one accepted input beat; a last beat queues the verdict
    function void note_beat(in_t beat);
      out_t v;
      bit ok;
      if (!beat.no_char) take_char(beat.ch);
      if (!beat.last) return;
      ok = !rejected && count >= min_len && count <= max_len;
      if (ok && bag_live() && bag_mode_e'(opts[3:2]) == BagExact && !opts[1]) begin
        for (int k = 0; k < SlotCount; k++) begin
          if (bag_at(k) != 8'h00 && !used[k]) ok = 1'b0;
        end
      end
      v.accept      = ok;
      v.word_length = count;
      pending.push_back(v);
      clear_word();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= ReportLimit) $display("MISMATCH: %s", msg);
    endfunction

    // Check one accepted result beat against the oldest verdict
    function void check_verdict(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        flag($sformatf("verdict with none pending: accept=%0d length=%0d",
                       got.accept, got.word_length));
        return;
      end
      exp = pending.pop_front();
      verdicts++;
      if (got.accept !== exp.accept)
        flag($sformatf("word %0d accept: expected %0d, got %0d",
                       verdicts, exp.accept, got.accept));
      if (got.word_length !== exp.word_length)
        flag($sformatf("word %0d length: expected %0d, got %0d",
                       verdicts, exp.word_length, got.word_length));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [2:0]          cfg_idx_i   = CfgMinLength;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  verdict_board board;
  int unsigned  cycles    = 0;
  int unsigned  send_idle = 14;
  int unsigned  recv_idle = 53;
  int unsigned  words_sent;
  int unsigned  beats_sent;
  int unsigned  settings_done;

  // Current register setting and the word it is built around
  logic [6:0]   min_sel;
  logic [6:0]   max_sel;
  logic [3:0]   opt_sel;
  logic [127:0] tmpl_v;
  logic [127:0] bag_v;
  logic [7:0]   seed_q[$];
  logic [7:0]   word_q[$];

  word_template_letter_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random back-pressure on the result channel
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  // Watch both channels at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_beat(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_verdict(out_data_o);
    end
  end

  // Guard against a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding",
               cycles, board.pending.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one beat, idling at random first, and hold it until taken
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_ignored();
    in_t beat;
    beat.ch      = 8'($urandom_range(255));
    beat.last    = 1'b0;
    beat.no_char = 1'b1;
    send_beat(beat);
  endtask

  // Stream word_q; an empty queue becomes a lone no-character last beat, and any word may end with one
  task automatic send_word();
    int n;
    bit tail_empty;
    in_t beat;
    n = word_q.size();
    tail_empty = (n == 0) || ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) send_ignored();
      beat.ch      = word_q[i];
      beat.last    = (i == n - 1) && !tail_empty;
      beat.no_char = 1'b0;
      send_beat(beat);
      beats_sent++;
    end
    if (tail_empty) begin
      beat.ch      = 8'($urandom_range(255));
      beat.last    = 1'b1;
      beat.no_char = 1'b1;
      send_beat(beat);
      beats_sent++;
    end
    words_sent++;
  endtask

  // Pause the sender until every verdict is back and the block is quiet
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Narrow registers get random upper bits, which the block must drop
  task automatic apply_setting();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(CfgMinLength, {junk[63:7], min_sel});
    junk = {$urandom, $urandom};
    put_reg(CfgMaxLength, {junk[63:7], max_sel});
    junk = {$urandom, $urandom};
    put_reg(CfgOptions, {junk[63:4], opt_sel});
    put_reg(CfgTemplateLow, tmpl_v[63:0]);
    put_reg(CfgTemplateHigh, tmpl_v[127:64]);
    put_reg(CfgBagLow, bag_v[63:0]);
    put_reg(CfgBagHigh, bag_v[127:64]);
    if ($urandom_range(1) == 0) put_reg(CfgUnused, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  task automatic set_text(input string s);
    word_q.delete();
    for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
  endtask

  task automatic shuffle_word();
    logic [7:0] t;
    int j;
    for (int i = word_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = word_q[i];
      word_q[i] = word_q[j];
      word_q[j] = t;
    end
  endtask

  // Build a setting around a random seed word so that matching words exist
  task automatic make_setting(input int p);
    int n;
    int slot;
    int tl;
    logic [7:0] c;

    seed_q.delete();
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) seed_q.push_back(8'h41 + 8'($urandom_range(25)));
    if ($urandom_range(4) == 0) seed_q.push_back(StarChar);
    if ($urandom_range(4) == 0) seed_q.push_back(HyphenChar);
    n = seed_q.size();

    opt_sel = 4'($urandom_range(15));
    opt_sel[3:2] = 2'(p % 4);

    // scatter the seed letters over the bag, some in lower case
    bag_v = '0;
    for (int i = 0; i < n + ((opt_sel[3:2] == BagExact) ? 0 : 3); i++) begin
      c = (i < n) ? seed_q[i] : 8'h41 + 8'($urandom_range(25));
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(3) == 0) c = c + 8'h20;
      do slot = $urandom_range(15); while (bag_v[8*slot +: 8] != 8'h00);
      bag_v[8*slot +: 8] = c;
    end

    // template follows the seed word, with some stars, and junk past its end
    tmpl_v = '0;
    tl = ($urandom_range(3) == 0) ? $urandom_range(0, n) : n;
    for (int i = 0; i < SlotCount; i++) begin
      if (i < tl) begin
        c = seed_q[i];
        if ($urandom_range(2) == 0) c = StarChar;
        else if (c >= 8'h41 && c <= 8'h5A && $urandom_range(3) == 0) c = c + 8'h20;
        tmpl_v[8*i +: 8] = c;
      end else if (i > tl) begin
        tmpl_v[8*i +: 8] = 8'($urandom_range(255));
      end
    end

    min_sel = 7'($urandom_range(0, n));
    max_sel = ($urandom_range(3) == 0) ? 7'd127 : 7'($urandom_range(n, 40));

    // some settings push the registers to their extremes
    case (p)
      2: begin
        min_sel = 7'($urandom_range(5, 127));
        max_sel = 7'($urandom_range(0, min_sel - 1));
      end
      4: begin
        tmpl_v  = '1;
        bag_v   = '1;
        opt_sel = 4'h0;
        min_sel = 7'd0;
        max_sel = 7'd127;
        seed_q.delete();
        for (int i = 0; i < SlotCount; i++) seed_q.push_back(8'hFF);
      end
      6: begin
        tmpl_v = '0;
        for (int i = 0; i < SlotCount; i++)
          bag_v[8*i +: 8] = ($urandom_range(3) == 0) ? 8'h00 : StarChar;
        opt_sel = 4'hF;
        min_sel = 7'd127;
        max_sel = 7'd127;
      end
      default: ;
    endcase
  endtask

  // Pick a word: mostly the seed word or close to it, the rest noise
  task automatic make_word(input int p);
    int r;
    int n;
    int pos;
    r = $urandom_range(99);
    word_q.delete();
    if ((p == 6 && r < 15) || r == 99) begin
      n = $urandom_range(100, 140);
      for (int i = 0; i < n; i++) word_q.push_back(8'h41 + 8'($urandom_range(25)));
    end else if (r < 55) begin
      word_q = seed_q;
      if (r >= 35) shuffle_word();
    end else if (r < 70) begin
      word_q = seed_q;
      n = word_q.size();
      case ($urandom_range(2))
        0: word_q[$urandom_range(n - 1)] = 8'h41 + 8'($urandom_range(25));
        1: word_q.delete($urandom_range(n - 1));
        default: begin
          pos = $urandom_range(n);
          word_q.insert(pos, ($urandom_range(2) == 0) ? HyphenChar
                                                      : 8'h41 + 8'($urandom_range(25)));
        end
      endcase
    end else if (r < 85) begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0: word_q.push_back(HyphenChar);
          1: word_q.push_back(StarChar);
          default: word_q.push_back(8'h41 + 8'($urandom_range(25)));
        endcase
      end
    end else begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) word_q.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned start;
    board = new();
    words_sent    = 0;
    beats_sent    = 0;
    settings_done = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset setting, bag off, no hyphen, no template
    set_text("");
    send_word();
    send_ignored();
    word_q = '{8'h00};
    send_word();
    word_q = '{8'hFF};
    send_word();
    set_text("A-");
    send_word();

    // Directed: exact bag "tac" with a gap, template "c*t", length 2..3
    hold_until_drained();
    min_sel = 7'd2;
    max_sel = 7'd3;
    opt_sel = 4'b0001;
    tmpl_v  = '0;
    tmpl_v[7:0]   = "c";
    tmpl_v[15:8]  = "*";
    tmpl_v[23:16] = "t";
    bag_v = '0;
    bag_v[7:0]   = "t";
    bag_v[15:8]  = "a";
    bag_v[31:24] = "c";
    apply_setting();
    set_text("CAT");
    send_word();
    set_text("CAA");
    send_word();
    set_text("CA");
    send_word();

    // Directed: reusable letters lift the every-slot rule
    hold_until_drained();
    put_reg(CfgOptions, 64'(4'b0010));
    cfg_we_i <= 1'b0;
    set_text("CTT");
    send_word();

    // Random phases under the three idling regimes
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 3) begin
        send_idle = 14;
        recv_idle = 53;
      end else if (p < 6) begin
        send_idle = 53;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      hold_until_drained();
      make_setting(p);
      apply_setting();
      start = beats_sent;
      while (beats_sent - start < PhaseBeats) begin
        if ($urandom_range(9) == 0) send_ignored();
        make_word(p);
        send_word();
        if ($urandom_range(24) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (board.pending.size() != 0)
      board.flag($sformatf("%0d verdicts never arrived", board.pending.size()));

    $display("Ran %0d words (%0d character beats) under %0d register settings,",
             words_sent, beats_sent, settings_done);
    $display("all bag modes, template, hyphen and length limits; %0d verdicts checked.",
             board.verdicts);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", board.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
